/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

  localparam logic [15:0] HUE_FULL = 16'hFFFF;
  localparam logic [2:0]  SECTORS  = 3'd6;
  localparam logic [7:0]  ALPHA    = 8'hFF;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e     sector;
    logic [15:0] k;
    logic [15:0] chroma;
    logic [15:0] offset;
  } front_t;

  typedef struct packed {
    sector_e     sector;
    logic [15:0] x;
    logic [15:0] chroma;
    logic [15:0] offset;
  } mix_t;

endpackage

/* design/hsv2rgb_if.sv */
interface hsv2rgb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

interface hsv2rgb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_color;

  modport source (output valid, output packed_color, input ready);
  modport sink (input valid, input packed_color, output ready);
endinterface

/* design/hsv2rgb_sector.sv */
module hsv2rgb_sector (
  input  logic                clk_i,
  input  logic                rst_ni,
  hsv2rgb_in_if.sink          hsv_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsv2rgb_pkg::front_t front_o
);

  logic        a_valid_q;
  logic [18:0] a_t_q;
  logic [15:0] a_c_q;
  logic [7:0]  a_val_q;
  logic        a_ready;

  logic                b_valid_q;
  hsv2rgb_pkg::front_t b_q;
  hsv2rgb_pkg::front_t b_d;
  logic                b_ready;

  logic [2:0]           b_q_raw;
  logic [16:0]          b_rem;
  logic                 b_wrap;
  logic [2:0]           b_sec_raw;
  logic [15:0]          b_frac;
  logic                 b_odd;
  hsv2rgb_pkg::sector_e b_sector;

  assign b_ready     = !b_valid_q || ready_i;
  assign a_ready     = !a_valid_q || b_ready;
  assign hsv_i.ready = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= hsv_i.valid;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && hsv_i.valid) begin
      a_t_q   <= {1'b0, hsv_i.hue, 2'b00} + {2'b00, hsv_i.hue, 1'b0};
      a_c_q   <= 16'(hsv_i.saturation) * 16'(hsv_i.brightness);
      a_val_q <= hsv_i.brightness;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  // The hue is split by 65535 as t = 65536*q + lo = 65535*q + (lo + q).
  always_comb begin
    b_q_raw   = a_t_q[18:16];
    b_rem     = {1'b0, a_t_q[15:0]} + {14'd0, b_q_raw};
    b_wrap    = (b_rem >= {1'b0, hsv2rgb_pkg::HUE_FULL});
    b_sec_raw = b_q_raw + {2'd0, b_wrap};
    b_frac    = b_wrap ? 16'(b_rem - {1'b0, hsv2rgb_pkg::HUE_FULL}) : b_rem[15:0];
    if (b_sec_raw >= hsv2rgb_pkg::SECTORS) begin
      b_sector = hsv2rgb_pkg::SEC_RY;
      b_frac   = 16'd0;
    end else begin
      b_sector = hsv2rgb_pkg::sector_e'(b_sec_raw);
    end
    b_odd = (b_sector == hsv2rgb_pkg::SEC_YG) || (b_sector == hsv2rgb_pkg::SEC_CB) ||
            (b_sector == hsv2rgb_pkg::SEC_MR);
    b_d.sector = b_sector;
    b_d.k      = b_odd ? (hsv2rgb_pkg::HUE_FULL - b_frac) : b_frac;
    b_d.chroma = a_c_q;
    b_d.offset = 16'({a_val_q, 8'd0} - {8'd0, a_val_q}) - a_c_q;
  end

  assign valid_o = b_valid_q;
  assign front_o = b_q;

endmodule

/* design/hsv2rgb_blend.sv */
module hsv2rgb_blend (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hsv2rgb_pkg::front_t front_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsv2rgb_pkg::mix_t   mix_o
);

  logic                 c_valid_q;
  logic [31:0]          c_prod_q;
  hsv2rgb_pkg::sector_e c_sector_q;
  logic [15:0]          c_chroma_q;
  logic [15:0]          c_offset_q;
  logic                 c_ready;

  logic              d_valid_q;
  hsv2rgb_pkg::mix_t d_q;
  hsv2rgb_pkg::mix_t d_d;
  logic              d_ready;
  logic [16:0]       d_rem;

  assign d_ready = !d_valid_q || ready_i;
  assign c_ready = !c_valid_q || d_ready;
  assign ready_o = c_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && valid_i) begin
      c_prod_q   <= 32'(front_i.chroma) * 32'(front_i.k);
      c_sector_q <= front_i.sector;
      c_chroma_q <= front_i.chroma;
      c_offset_q <= front_i.offset;
    end
    if (d_ready && c_valid_q) begin
      d_q <= d_d;
    end
  end

  // The product stays below 65535 * 65536, so one correction step is exact.
  always_comb begin
    d_rem      = {1'b0, c_prod_q[31:16]} + {1'b0, c_prod_q[15:0]};
    d_d.sector = c_sector_q;
    d_d.x      = c_prod_q[31:16] + {15'd0, (d_rem >= {1'b0, hsv2rgb_pkg::HUE_FULL})};
    d_d.chroma = c_chroma_q;
    d_d.offset = c_offset_q;
  end

  assign valid_o = d_valid_q;
  assign mix_o   = d_q;

endmodule

/* design/hsv2rgb_pack.sv */
module hsv2rgb_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  hsv2rgb_pkg::mix_t mix_i,
  hsv2rgb_out_if.source     rgb_o
);

  logic        e_valid_q;
  logic [31:0] e_color_q;
  logic        e_ready;
  logic [15:0] part_r;
  logic [15:0] part_g;
  logic [15:0] part_b;
  logic [31:0] color_d;

  // Exact division by 255 for a 16-bit dividend whose quotient fits in 8 bits.
  function automatic logic [7:0] div255(input logic [15:0] s);
    logic [16:0] acc;
    acc = {1'b0, s} + {9'd0, s[15:8]} + 17'd1;
    return acc[15:8];
  endfunction

  assign e_ready = !e_valid_q || rgb_o.ready;
  assign ready_o = e_ready;

  always_comb begin
    part_r = 16'd0;
    part_g = 16'd0;
    part_b = 16'd0;
    case (mix_i.sector)
      hsv2rgb_pkg::SEC_RY: begin
        part_r = mix_i.chroma;
        part_g = mix_i.x;
      end
      hsv2rgb_pkg::SEC_YG: begin
        part_r = mix_i.x;
        part_g = mix_i.chroma;
      end
      hsv2rgb_pkg::SEC_GC: begin
        part_g = mix_i.chroma;
        part_b = mix_i.x;
      end
      hsv2rgb_pkg::SEC_CB: begin
        part_g = mix_i.x;
        part_b = mix_i.chroma;
      end
      hsv2rgb_pkg::SEC_BM: begin
        part_r = mix_i.x;
        part_b = mix_i.chroma;
      end
      default: begin
        part_r = mix_i.chroma;
        part_b = mix_i.x;
      end
    endcase
    color_d = {hsv2rgb_pkg::ALPHA,
               div255(part_r + mix_i.offset),
               div255(part_g + mix_i.offset),
               div255(part_b + mix_i.offset)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (e_ready) begin
      e_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_ready && valid_i) begin
      e_color_q <= color_d;
    end
  end

  assign rgb_o.valid        = e_valid_q;
  assign rgb_o.packed_color = e_color_q;

endmodule

/* design/hsv_to_rgb_converter.sv */
// HSV to RGB color converter for a stream of pixels.
// The input channel hsv_i carries one word per pixel: a 16-bit hue that spans
// the full circle, an 8-bit saturation and an 8-bit brightness. The output
// channel rgb_o carries one packed 32-bit color per pixel with alpha 0xFF in
// the top byte, then red, green and blue.
// The datapath has five register stages: hue times six with chroma, hue sector
// split, chroma times fraction, fraction scaling, and the channel sums with
// division by 255.
// A result is registered in each of these stages in turn before it reaches rgb_o.
// One word is accepted in every cycle while rgb_o is not stalled, so throughput is one pixel per clock.
// Every stage holds a valid bit; a stage loads when it is empty or when the
// stage after it moves, so a stalled receiver fills the pipeline and then
// drops hsv_i.ready without losing or repeating any word.
// Reset clears all valid bits, so the output is empty and the block is ready
// right after reset.
module hsv_to_rgb_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsv2rgb_in_if.sink    hsv_i,
  hsv2rgb_out_if.source rgb_o
);

  logic                front_valid;
  logic                front_ready;
  hsv2rgb_pkg::front_t front;
  logic                mix_valid;
  logic                mix_ready;
  hsv2rgb_pkg::mix_t   mix;

  hsv2rgb_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hsv_i   (hsv_i),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .front_o (front)
  );

  hsv2rgb_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .front_i (front),
    .valid_o (mix_valid),
    .ready_i (mix_ready),
    .mix_o   (mix)
  );

  hsv2rgb_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .ready_o (mix_ready),
    .mix_i   (mix),
    .rgb_o   (rgb_o)
  );

endmodule

/* design/hsv2rgb_checker.sv */
`include "assert_macros.svh"

module hsv2rgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_color_i
);

  `ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> !out_valid_i, "output valid during reset")

  `ASSERT_CLKD(a_alpha_full, clk_i, rst_ni, out_valid_i |-> out_color_i[31:24] == hsv2rgb_pkg::ALPHA, "alpha byte is not full")

  `ASSERT_CLKD(a_ready_when_drained, clk_i, rst_ni, (!out_valid_i || out_ready_i) |-> in_ready_i, "input stalled while output moves")

  `ASSERT_CLKD(a_stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_color_i), "stalled output word changed")

  logic unused_in_valid;
  assign unused_in_valid = in_valid_i;

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hsv_i.valid),
  .in_ready_i  (hsv_i.ready),
  .out_valid_i (rgb_o.valid),
  .out_ready_i (rgb_o.ready),
  .out_color_i (rgb_o.packed_color)
);
